@@ src/deq_pkg.sv @@
// shared types and codes for the double-ended queue
// no dependencies; used by every other file in src except deq_ram

package deq_pkg;

   localparam int WORD_W = 32;
   localparam int FUNC_W = 3;
   localparam int STAT_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic exec;
      logic capture;
      logic scan_step;
      logic load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_pop;
      logic is_search;
      logic empty;
      logic scan_hit;
      logic scan_last;
   } stat_type;

endpackage

@@ src/deq_if.sv @@
// valid/ready channel interfaces for operation requests and responses
// depends on deq_pkg for field widths

interface deq_req_if;
   logic                              valid;
   logic                              ready;
   logic [deq_pkg::FUNC_W-1:0]        func;
   logic signed [deq_pkg::WORD_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink (input valid, input func, input value, output ready);
endinterface

interface deq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [deq_pkg::WORD_W-1:0] data_out;
   logic [deq_pkg::STAT_W-1:0]        status;
   logic                              found;
   logic                              is_empty;

   modport source (output valid, output data_out, output status, output found,
                   output is_empty, input ready);
   modport sink (input valid, input data_out, input status, input found,
                 input is_empty, output ready);
endinterface

@@ src/deq_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/deq_datapath.sv @@
// datapath: ring pointers, occupancy, entry ram, search compare and response registers
// depends on deq_pkg and deq_ram

module deq_datapath #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  deq_pkg::cmd_type                  cmd,
   output deq_pkg::stat_type                 stat,
   input  logic [deq_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [deq_pkg::WORD_W-1:0] req_value,
   output logic signed [deq_pkg::WORD_W-1:0] rsp_data_out,
   output logic [deq_pkg::STAT_W-1:0]        rsp_status,
   output logic                              rsp_found,
   output logic                              rsp_is_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW:0]   DEPTH_W  = (CW+1)'(DEPTH);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] occ_ff, occ_in;
   logic [deq_pkg::FUNC_W-1:0] func_ff;
   logic signed [deq_pkg::WORD_W-1:0] value_ff;
   logic [AW-1:0] ptr_ff;
   logic [CW-1:0] rem_ff;
   logic signed [deq_pkg::WORD_W-1:0] data_ff;
   logic [deq_pkg::STAT_W-1:0] status_ff;
   logic found_ff;
   logic signed [deq_pkg::WORD_W-1:0] out_data_ff;
   logic [deq_pkg::STAT_W-1:0] out_status_ff;
   logic out_found_ff;
   logic out_empty_ff;

   logic [CW:0]   tail_sum, last_sum;
   logic [AW-1:0] tail_idx, last_idx, front_inc, front_dec, ptr_inc;
   logic          full, empty, is_push, is_pop, is_search;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [deq_pkg::WORD_W-1:0] rd_data;

   // ring index arithmetic
   assign tail_sum  = (CW+1)'(front_ff) + (CW+1)'(occ_ff);
   assign last_sum  = tail_sum - 1'b1;
   assign tail_idx  = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
   assign last_idx  = (last_sum >= DEPTH_W) ? AW'(last_sum - DEPTH_W) : AW'(last_sum);
   assign front_inc = (front_ff == LAST_IDX) ? '0 : AW'(front_ff + 1'b1);
   assign front_dec = (front_ff == '0) ? LAST_IDX : AW'(front_ff - 1'b1);
   assign ptr_inc   = (ptr_ff == LAST_IDX) ? '0 : AW'(ptr_ff + 1'b1);

   assign full  = (occ_ff == FULL_CNT);
   assign empty = (occ_ff == '0);

   assign is_push   = (func_ff == deq_pkg::OP_PUSH_BACK) || (func_ff == deq_pkg::OP_PUSH_FRONT);
   assign is_pop    = (func_ff == deq_pkg::OP_POP_FRONT) || (func_ff == deq_pkg::OP_POP_BACK);
   assign is_search = (func_ff == deq_pkg::OP_SEARCH);

   assign stat.is_pop    = is_pop;
   assign stat.is_search = is_search;
   assign stat.empty     = empty;
   assign stat.scan_hit  = (rd_data == value_ff);
   assign stat.scan_last = (rem_ff == CW'(1));

   always_comb begin
      front_in = front_ff;
      occ_in   = occ_ff;
      wr_en    = 1'b0;
      wr_addr  = tail_idx;
      rd_addr  = ptr_ff;
      if (cmd.exec) begin
         case (deq_pkg::op_type'(func_ff))
            deq_pkg::OP_PUSH_BACK: begin
               if (!full) begin
                  wr_en  = 1'b1;
                  occ_in = CW'(occ_ff + 1'b1);
               end
            end
            deq_pkg::OP_PUSH_FRONT: begin
               wr_addr = front_dec;
               if (!full) begin
                  wr_en    = 1'b1;
                  front_in = front_dec;
                  occ_in   = CW'(occ_ff + 1'b1);
               end
            end
            deq_pkg::OP_POP_FRONT: begin
               rd_addr = front_ff;
               if (!empty) begin
                  front_in = front_inc;
                  occ_in   = CW'(occ_ff - 1'b1);
               end
            end
            deq_pkg::OP_POP_BACK: begin
               rd_addr = last_idx;
               if (!empty) begin
                  occ_in = CW'(occ_ff - 1'b1);
               end
            end
            deq_pkg::OP_SEARCH: begin
               rd_addr = front_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         occ_ff   <= '0;
      end else begin
         front_ff <= front_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff   <= req_func;
         value_ff  <= req_value;
         data_ff   <= '0;
         status_ff <= deq_pkg::ST_OK;
         found_ff  <= 1'b0;
      end
      if (cmd.exec) begin
         if (is_pop && empty) begin
            data_ff   <= '1;
            status_ff <= deq_pkg::ST_EMPTY;
         end
         if (is_push && full) begin
            status_ff <= deq_pkg::ST_FULL;
         end
         ptr_ff <= front_inc;
         rem_ff <= occ_ff;
      end
      if (cmd.capture) begin
         data_ff <= rd_data;
      end
      if (cmd.scan_step) begin
         ptr_ff   <= ptr_inc;
         rem_ff   <= CW'(rem_ff - 1'b1);
         found_ff <= stat.scan_hit;
      end
      if (cmd.load) begin
         out_data_ff   <= data_ff;
         out_status_ff <= status_ff;
         out_found_ff  <= found_ff;
         out_empty_ff  <= empty;
      end
   end

   deq_ram #(
      .WIDTH (deq_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_data_out = out_data_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_found    = out_found_ff;
   assign rsp_is_empty = out_empty_ff;

endmodule

@@ src/deq_ctrl.sv @@
// controller: sequences one operation at a time and owns the response valid flag
// depends on deq_pkg

module deq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  deq_pkg::stat_type stat,
   output deq_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RDWAIT,
      S_SCAN,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.is_pop && !stat.empty) begin
               state_in = S_RDWAIT;
            end else if (stat.is_search && !stat.empty) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RDWAIT: begin
            cmd.capture = 1'b1;
            state_in    = S_RESP;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit || stat.scan_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/double_ended_queue.sv @@
// push, no-op, and pop or search on an empty queue go from S_EXEC to S_RESP; pop adds
// S_RDWAIT, search adds S_SCAN with k entries compared (up to DEPTH) before response valid
// a new request is taken only in S_IDLE, once the previous response has been loaded;
// the search compares one held entry per cycle through the single read port of the ram
// synchronous active-high reset empties the queue; entries are not cleared
// depends on deq_pkg, deq_if, deq_ctrl and deq_datapath

module double_ended_queue #(
   parameter int DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);

   deq_pkg::cmd_type  cmd;
   deq_pkg::stat_type stat;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   deq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_func     (req_chan.func),
      .req_value    (req_chan.value),
      .rsp_data_out (rsp_chan.data_out),
      .rsp_status   (rsp_chan.status),
      .rsp_found    (rsp_chan.found),
      .rsp_is_empty (rsp_chan.is_empty)
   );

endmodule

@@ src/deq_checker.sv @@
// port-level checks for the double-ended queue, bound to the top level
// depends on deq_pkg and double_ended_queue

module deq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [deq_pkg::WORD_W-1:0] data_out,
   input logic [deq_pkg::STAT_W-1:0]        status,
   input logic                              found,
   input logic                              is_empty
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_out) && $stable(status)
         && $stable(found) && $stable(is_empty))
      else $error("stalled response changed");

   // one transaction in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == deq_pkg::ST_EMPTY) |-> (data_out == -1) && is_empty && !found)
      else $error("empty pop response malformed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == deq_pkg::ST_FULL) |-> (data_out == 0) && !is_empty && !found)
      else $error("full push response malformed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && found |-> (status == deq_pkg::ST_OK) && (data_out == 0) && !is_empty)
      else $error("search hit response malformed");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .data_out  (rsp_chan.data_out),
   .status    (rsp_chan.status),
   .found     (rsp_chan.found),
   .is_empty  (rsp_chan.is_empty)
);
